FILE: rtl/lpfd_pkg.sv
// shared types and constants of the length-prefixed frame decoder
`default_nettype none
package lpfd_pkg;

	localparam int unsigned DataW   = 8;
	localparam int unsigned IdW     = 16;
	localparam int unsigned LenW    = 32;
	localparam int unsigned StatusW = 2;

	// reset value of the payload limit
	localparam logic [LenW-1:0] MaxPayloadReset = 32'd65536;

	// result status codes
	localparam logic [StatusW-1:0] ST_PAYLOAD_BYTE = 2'd0;
	localparam logic [StatusW-1:0] ST_EMPTY_FRAME  = 2'd1;
	localparam logic [StatusW-1:0] ST_BODY_SMALL   = 2'd2;
	localparam logic [StatusW-1:0] ST_PAYLOAD_BIG  = 2'd3;

	// one result beat
	typedef struct packed {
		logic [StatusW-1:0] status;
		logic [IdW-1:0]     msg_id;
		logic [DataW-1:0]   payload_byte;
		logic               last_of_frame;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/lpfd_parser.sv
// frame parser: header gathering, length check, payload tagging
`default_nettype none
module lpfd_parser (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire [lpfd_pkg::LenW-1:0]         max_payload,
	input  wire                              item_valid,
	input  wire [lpfd_pkg::DataW-1:0]        item_byte,
	input  wire                              res_free,
	output logic                             item_take,
	output logic                             res_valid,
	output lpfd_pkg::result_t                res
);

	typedef enum logic [1:0] {
		PH_LENGTH,
		PH_ID,
		PH_PAYLOAD,
		PH_ERROR
	} phase_t;

	phase_t                                  phase_q;
	logic [1:0]                              hdr_cnt_q;
	logic [lpfd_pkg::LenW-lpfd_pkg::DataW-1:0] len_q;
	logic [lpfd_pkg::IdW-1:0]                id_q;
	logic [lpfd_pkg::LenW-1:0]               remain_q;

	logic [lpfd_pkg::LenW-1:0]               len_full;
	logic [lpfd_pkg::LenW-1:0]               pay_len;
	logic [lpfd_pkg::LenW-1:0]               remain_dec;
	logic [lpfd_pkg::IdW-1:0]                id_full;
	logic                                    body_small;
	logic                                    too_large;
	logic                                    res_want;

	assign len_full   = {len_q, item_byte};
	assign pay_len    = len_full - 32'd2;
	assign body_small = (len_full < 32'd2);
	assign too_large  = (pay_len > max_payload);
	assign remain_dec = remain_q - 32'd1;
	assign id_full    = {id_q[lpfd_pkg::IdW-lpfd_pkg::DataW-1:0], item_byte};

	always_comb begin
		res_want = 1'b0;
		res      = '0;
		case (phase_q)
			PH_LENGTH: begin
				if (hdr_cnt_q == 2'd3) begin
					if (body_small) begin
						res_want          = 1'b1;
						res.status        = lpfd_pkg::ST_BODY_SMALL;
						res.last_of_frame = 1'b1;
					end else if (too_large) begin
						res_want          = 1'b1;
						res.status        = lpfd_pkg::ST_PAYLOAD_BIG;
						res.last_of_frame = 1'b1;
					end
				end
			end
			PH_ID: begin
				if (hdr_cnt_q == 2'd1 && remain_q == '0) begin
					res_want          = 1'b1;
					res.status        = lpfd_pkg::ST_EMPTY_FRAME;
					res.msg_id        = id_full;
					res.last_of_frame = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				res_want          = 1'b1;
				res.status        = lpfd_pkg::ST_PAYLOAD_BYTE;
				res.msg_id        = id_q;
				res.payload_byte  = item_byte;
				res.last_of_frame = (remain_dec == '0);
			end
			default: begin
				res_want = 1'b0;
			end
		endcase
	end

	assign item_take = item_valid && (!res_want || res_free);
	assign res_valid = item_take && res_want;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LENGTH;
			hdr_cnt_q <= 2'd0;
			len_q     <= '0;
			id_q      <= '0;
			remain_q  <= '0;
		end else if (item_take) begin
			case (phase_q)
				PH_LENGTH: begin
					len_q     <= len_full[lpfd_pkg::LenW-lpfd_pkg::DataW-1:0];
					hdr_cnt_q <= hdr_cnt_q + 2'd1;
					if (hdr_cnt_q == 2'd3) begin
						if (body_small || too_large) begin
							phase_q <= PH_ERROR;
						end else begin
							remain_q <= pay_len;
							phase_q  <= PH_ID;
						end
					end
				end
				PH_ID: begin
					id_q <= id_full;
					if (hdr_cnt_q == 2'd1) begin
						hdr_cnt_q <= 2'd0;
						phase_q   <= (remain_q == '0) ? PH_LENGTH : PH_PAYLOAD;
					end else begin
						hdr_cnt_q <= hdr_cnt_q + 2'd1;
					end
				end
				PH_PAYLOAD: begin
					remain_q <= remain_dec;
					if (remain_dec == '0) begin
						phase_q <= PH_LENGTH;
					end
				end
				default: begin
					phase_q <= PH_ERROR;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/length_prefixed_frame_decoder_core.sv
// top level of the length-prefixed frame decoder
//
// channel  dir  handshake              payload
// s_*      in   s_tvalid / s_tready    tdata[7:0] raw stream byte
// m_*      out  m_tvalid / m_tready    tdata id+byte, tuser status, tlast end of frame
// cfg_*    in   cfg_valid / cfg_ready  cfg_data = max_payload_bytes
//
// one byte beat per cycle sustained unless the result stream stalls: input register,
// parser logic, result register; a payload byte passes both registers on its way out
// arst_n clears the parser to the length phase and the limit to 65536
// a stalled result blocks only bytes that would make a result; other header bytes keep flowing
// after a length error every byte is taken and dropped until reset
`default_nettype none
module length_prefixed_frame_decoder_core (
	input  wire                          clk,
	input  wire                          arst_n,
	// stream in
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [7:0]                   s_tdata,    // [7:0] data_byte
	// result stream out
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [23:0]                  m_tdata,    // [15:0] msg_id, [23:16] payload_byte
	output logic [1:0]                   m_tuser,    // [1:0] status
	output logic                         m_tlast,    // last_of_frame
	// limit register write
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [lpfd_pkg::LenW-1:0]    cfg_data
);

	// payload limit, always writable
	logic [lpfd_pkg::LenW-1:0]  max_payload_q;

	// input register
	logic                       valid_s1;
	logic [lpfd_pkg::DataW-1:0] byte_s1;

	// result register
	logic                       out_valid_q;
	lpfd_pkg::result_t          out_q;

	logic                       item_take;
	logic                       res_valid;
	logic                       res_free;
	lpfd_pkg::result_t          res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= lpfd_pkg::MaxPayloadReset;
		end else if (cfg_valid) begin
			max_payload_q <= cfg_data;
		end
	end

	// the input register frees up whenever its byte moves on this cycle
	assign s_tready = !valid_s1 || item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (item_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// a result can be loaded when the output is empty or drains this cycle
	assign res_free = !out_valid_q || m_tready;

	lpfd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_payload (max_payload_q),
		.item_valid  (valid_s1),
		.item_byte   (byte_s1),
		.res_free    (res_free),
		.item_take   (item_take),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.payload_byte, out_q.msg_id};
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last_of_frame;

endmodule
`default_nettype wire
